FILE: sv/cbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cbp_pkg;

  localparam int MAX_BOXES = 8;
  localparam int BOX_W     = 3;
  localparam int CNT_W     = 4;

  localparam int MUL_W     = 17;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int RAD_W     = 30;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int NUM_W     = 32;
  localparam int DEN_W     = ROOT_W + 1;

  localparam logic [14:0] RADIUS_RESET = 15'd115;

  typedef enum logic {
    REQ_LOAD    = 1'b0,
    REQ_RESOLVE = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic               req_type;
    logic [2:0]         box_index;
    logic               entry_valid;
    logic signed [15:0] center_x;
    logic signed [15:0] center_z;
    logic [14:0]        half_x;
    logic [14:0]        half_z;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_z;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_z;
    logic [3:0]         push_count;
    logic               popped;
  } out_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_R2,
    ST_CLAMP,
    ST_DX,
    ST_DZ,
    ST_SQRT,
    ST_MX,
    ST_VX,
    ST_MZ,
    ST_VZ,
    ST_NEXT,
    ST_DONE
  } state_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] res;
    if (v > 18'sd32767) begin
      res = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: sv/cbp_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module cbp_mul (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [cbp_pkg::MUL_W-1:0]  a,
  input  wire logic [cbp_pkg::MUL_W-1:0]  b,
  output logic                            done,
  output logic [cbp_pkg::PROD_W-1:0]      product
);

  localparam int CW = $clog2(cbp_pkg::MUL_W + 1);

  logic [cbp_pkg::PROD_W-1:0] acc_r;
  logic [cbp_pkg::PROD_W-1:0] mcand_r;
  logic [cbp_pkg::MUL_W-1:0]  mplier_r;
  logic [CW-1:0]              cnt_r;
  logic                       run_r;
  logic                       done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(cbp_pkg::MUL_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= '0;
      mcand_r  <= {{(cbp_pkg::PROD_W - cbp_pkg::MUL_W){1'b0}}, a};
      mplier_r <= b;
    end else if (run_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= {mcand_r[cbp_pkg::PROD_W-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[cbp_pkg::MUL_W-1:1]};
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule
`default_nettype wire

FILE: sv/cbp_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module cbp_isqrt (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [cbp_pkg::RAD_W-1:0]  rad,
  output logic                            done,
  output logic [cbp_pkg::ROOT_W-1:0]      root
);

  localparam int RW = cbp_pkg::ROOT_W + 2;
  localparam int CW = $clog2(cbp_pkg::ROOT_W + 1);

  logic [cbp_pkg::RAD_W-1:0]  rad_r;
  logic [RW-1:0]              rem_r;
  logic [cbp_pkg::ROOT_W-1:0] root_r;
  logic [CW-1:0]              cnt_r;
  logic                       run_r;
  logic                       done_r;
  logic [RW+1:0]              trial;

  assign trial = {rem_r, rad_r[cbp_pkg::RAD_W-1 -: 2]} - {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(cbp_pkg::ROOT_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      rad_r <= {rad_r[cbp_pkg::RAD_W-3:0], 2'b00};
      if (!trial[RW+1]) begin
        rem_r  <= trial[RW-1:0];
        root_r <= {root_r[cbp_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= {rem_r[RW-3:0], rad_r[cbp_pkg::RAD_W-1 -: 2]};
        root_r <= {root_r[cbp_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

FILE: sv/cbp_div.sv
`timescale 1ns / 1ps
`default_nettype none
module cbp_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [cbp_pkg::NUM_W-1:0]  num,
  input  wire logic [cbp_pkg::DEN_W-1:0]  den,
  output logic                            done,
  output logic [cbp_pkg::NUM_W-1:0]       quot
);

  localparam int CW = $clog2(cbp_pkg::NUM_W + 1);

  logic [cbp_pkg::NUM_W-1:0] num_r;
  logic [cbp_pkg::NUM_W-1:0] q_r;
  logic [cbp_pkg::DEN_W-1:0] den_r;
  logic [cbp_pkg::DEN_W-1:0] rem_r;
  logic [CW-1:0]             cnt_r;
  logic                      run_r;
  logic                      done_r;
  logic [cbp_pkg::DEN_W:0]   shifted;
  logic                      fits;

  assign shifted = {rem_r, num_r[cbp_pkg::NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(cbp_pkg::NUM_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (run_r) begin
      num_r <= {num_r[cbp_pkg::NUM_W-2:0], 1'b0};
      q_r   <= {q_r[cbp_pkg::NUM_W-2:0], fits};
      if (fits) begin
        rem_r <= shifted[cbp_pkg::DEN_W-1:0] - den_r;
      end else begin
        rem_r <= shifted[cbp_pkg::DEN_W-1:0];
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
`default_nettype wire

FILE: sv/circle_box_pushout_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                              Transfer
// input     start, busy, in_req                start && !busy
// result    out_strobe, out_res                out_strobe, one cycle
// config    cfg_valid, cfg_ready, cfg_data     cfg_valid && cfg_ready
//
// Load request: result in the cycle after accept; the next request is accepted only after the strobe.
// Resolve request: squares the radius, then per box skips a disabled box, squares dx and dz
// for a tested box without a push (miss or +X pop), and for a pushed box also runs the root and two divisions.
// These steps use the bit-serial multiplier, root unit and divider.
// Reset clears the enable bits and sets the radius to 115; no clearing pass.
// Results cannot be stalled; busy stays high through the result strobe cycle.
module circle_box_pushout_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire cbp_pkg::in_req_t  in_req,
  output logic                   out_strobe,
  output cbp_pkg::out_res_t      out_res,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [14:0]       cfg_data
);

  cbp_pkg::state_t state_r, state_nxt;

  logic signed [15:0] tcx_r [cbp_pkg::MAX_BOXES];
  logic signed [15:0] tcz_r [cbp_pkg::MAX_BOXES];
  logic [14:0]        thx_r [cbp_pkg::MAX_BOXES];
  logic [14:0]        thz_r [cbp_pkg::MAX_BOXES];
  logic [cbp_pkg::MAX_BOXES-1:0] en_r;

  logic [14:0]                 radius_r;
  logic [cbp_pkg::BOX_W-1:0]   box_r;
  logic signed [15:0]          px_r, pz_r;
  logic [cbp_pkg::RAD_W-1:0]   r2_r;
  logic [cbp_pkg::PROD_W-1:0]  sq_r;
  logic [cbp_pkg::MUL_W-1:0]   dxm_r, dzm_r;
  logic                        dxn_r, dzn_r;
  logic [cbp_pkg::ROOT_W-1:0]  d_r, gap_r;
  logic [cbp_pkg::CNT_W-1:0]   count_r;
  logic                        pop_r;

  logic                        accept;
  logic                        mul_start, mul_done, sqrt_start, sqrt_done, div_start, div_done;
  logic [cbp_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic [cbp_pkg::PROD_W-1:0]  product;
  logic [cbp_pkg::ROOT_W-1:0]  root;
  logic [cbp_pkg::NUM_W-1:0]   div_num, quot;
  logic [cbp_pkg::DEN_W-1:0]   div_den;

  logic signed [17:0] lo_x, hi_x, lo_z, hi_z, p_x, p_z, n_x, n_z, dx, dz;
  logic [cbp_pkg::MUL_W-1:0]   dx_mag, dz_mag;
  logic [cbp_pkg::PROD_W:0]    d2;
  logic [cbp_pkg::ROOT_W-1:0]  gap;
  logic signed [17:0]          q_s, new_x, new_z, pop_x;

  assign accept    = start && !busy;
  assign busy      = (state_r != cbp_pkg::ST_IDLE);
  assign cfg_ready = (state_r == cbp_pkg::ST_IDLE);

  always_comb begin
    lo_x = 18'(tcx_r[box_r]) - $signed({3'b000, thx_r[box_r]});
    hi_x = 18'(tcx_r[box_r]) + $signed({3'b000, thx_r[box_r]});
    lo_z = 18'(tcz_r[box_r]) - $signed({3'b000, thz_r[box_r]});
    hi_z = 18'(tcz_r[box_r]) + $signed({3'b000, thz_r[box_r]});
    p_x  = 18'(px_r);
    p_z  = 18'(pz_r);
    n_x  = (p_x < lo_x) ? lo_x : ((p_x > hi_x) ? hi_x : p_x);
    n_z  = (p_z < lo_z) ? lo_z : ((p_z > hi_z) ? hi_z : p_z);
    dx   = p_x - n_x;
    dz   = p_z - n_z;
    dx_mag = dx[17] ? cbp_pkg::MUL_W'(-dx) : dx[cbp_pkg::MUL_W-1:0];
    dz_mag = dz[17] ? cbp_pkg::MUL_W'(-dz) : dz[cbp_pkg::MUL_W-1:0];
    d2     = {1'b0, sq_r} + {1'b0, product};
    gap    = radius_r - root;
    q_s    = $signed({1'b0, quot[16:0]});
    new_x  = dxn_r ? (p_x - q_s) : (p_x + q_s);
    new_z  = dzn_r ? (p_z - q_s) : (p_z + q_s);
    pop_x  = 18'(tcx_r[box_r]) + $signed({3'b000, thx_r[box_r]})
           + $signed({3'b000, radius_r});
  end

  always_comb begin
    state_nxt  = state_r;
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    mul_a      = {2'b00, radius_r};
    mul_b      = {2'b00, radius_r};
    div_num    = {product[cbp_pkg::NUM_W-2:0], 1'b0}
               + {{(cbp_pkg::NUM_W - cbp_pkg::ROOT_W){1'b0}}, d_r};
    div_den    = {d_r, 1'b0};
    case (state_r)
      cbp_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_req.req_type == cbp_pkg::REQ_RESOLVE) begin
            state_nxt = cbp_pkg::ST_R2;
            mul_start = 1'b1;
          end else begin
            state_nxt = cbp_pkg::ST_DONE;
          end
        end
      end
      cbp_pkg::ST_R2: begin
        if (mul_done) begin
          state_nxt = cbp_pkg::ST_CLAMP;
        end
      end
      cbp_pkg::ST_CLAMP: begin
        if (en_r[box_r]) begin
          state_nxt = cbp_pkg::ST_DX;
          mul_start = 1'b1;
          mul_a     = dx_mag;
          mul_b     = dx_mag;
        end else begin
          state_nxt = cbp_pkg::ST_NEXT;
        end
      end
      cbp_pkg::ST_DX: begin
        mul_a = dzm_r;
        mul_b = dzm_r;
        if (mul_done) begin
          state_nxt = cbp_pkg::ST_DZ;
          mul_start = 1'b1;
        end
      end
      cbp_pkg::ST_DZ: begin
        if (mul_done) begin
          if (d2 >= {{(cbp_pkg::PROD_W + 1 - cbp_pkg::RAD_W){1'b0}}, r2_r}) begin
            state_nxt = cbp_pkg::ST_NEXT;
          end else if (d2 == '0) begin
            state_nxt = cbp_pkg::ST_NEXT;
          end else begin
            state_nxt  = cbp_pkg::ST_SQRT;
            sqrt_start = 1'b1;
          end
        end
      end
      cbp_pkg::ST_SQRT: begin
        mul_a = dxm_r;
        mul_b = {2'b00, gap};
        if (sqrt_done) begin
          state_nxt = cbp_pkg::ST_MX;
          mul_start = 1'b1;
        end
      end
      cbp_pkg::ST_MX: begin
        if (mul_done) begin
          state_nxt = cbp_pkg::ST_VX;
          div_start = 1'b1;
        end
      end
      cbp_pkg::ST_VX: begin
        mul_a = dzm_r;
        mul_b = {2'b00, gap_r};
        if (div_done) begin
          state_nxt = cbp_pkg::ST_MZ;
          mul_start = 1'b1;
        end
      end
      cbp_pkg::ST_MZ: begin
        if (mul_done) begin
          state_nxt = cbp_pkg::ST_VZ;
          div_start = 1'b1;
        end
      end
      cbp_pkg::ST_VZ: begin
        if (div_done) begin
          state_nxt = cbp_pkg::ST_NEXT;
        end
      end
      cbp_pkg::ST_NEXT: begin
        if (box_r == cbp_pkg::BOX_W'(cbp_pkg::MAX_BOXES - 1)) begin
          state_nxt = cbp_pkg::ST_DONE;
        end else begin
          state_nxt = cbp_pkg::ST_CLAMP;
        end
      end
      cbp_pkg::ST_DONE: begin
        state_nxt = cbp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = cbp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cbp_pkg::ST_IDLE;
      en_r     <= '0;
      radius_r <= cbp_pkg::RADIUS_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        radius_r <= cfg_data;
      end
      if (accept && in_req.req_type == cbp_pkg::REQ_LOAD
          && {1'b0, in_req.box_index} < 4'(cbp_pkg::MAX_BOXES)) begin
        en_r[in_req.box_index] <= in_req.entry_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_req.req_type == cbp_pkg::REQ_LOAD
        && {1'b0, in_req.box_index} < 4'(cbp_pkg::MAX_BOXES)) begin
      tcx_r[in_req.box_index] <= in_req.center_x;
      tcz_r[in_req.box_index] <= in_req.center_z;
      thx_r[in_req.box_index] <= in_req.half_x;
      thz_r[in_req.box_index] <= in_req.half_z;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      cbp_pkg::ST_IDLE: begin
        if (accept) begin
          box_r   <= '0;
          count_r <= '0;
          pop_r   <= 1'b0;
          if (in_req.req_type == cbp_pkg::REQ_RESOLVE) begin
            px_r <= in_req.pos_x;
            pz_r <= in_req.pos_z;
          end else begin
            px_r <= '0;
            pz_r <= '0;
          end
        end
      end
      cbp_pkg::ST_R2: begin
        if (mul_done) begin
          r2_r <= product[cbp_pkg::RAD_W-1:0];
        end
      end
      cbp_pkg::ST_CLAMP: begin
        dxm_r <= dx_mag;
        dzm_r <= dz_mag;
        dxn_r <= dx[17];
        dzn_r <= dz[17];
      end
      cbp_pkg::ST_DX: begin
        if (mul_done) begin
          sq_r <= product;
        end
      end
      cbp_pkg::ST_DZ: begin
        if (mul_done
            && d2 < {{(cbp_pkg::PROD_W + 1 - cbp_pkg::RAD_W){1'b0}}, r2_r}) begin
          if (count_r != '1) begin
            count_r <= count_r + 1'b1;
          end
          if (d2 == '0) begin
            px_r  <= cbp_pkg::sat16(pop_x);
            pop_r <= 1'b1;
          end
        end
      end
      cbp_pkg::ST_SQRT: begin
        if (sqrt_done) begin
          d_r   <= root;
          gap_r <= gap;
        end
      end
      cbp_pkg::ST_VX: begin
        if (div_done) begin
          px_r <= cbp_pkg::sat16(new_x);
        end
      end
      cbp_pkg::ST_VZ: begin
        if (div_done) begin
          pz_r <= cbp_pkg::sat16(new_z);
        end
      end
      cbp_pkg::ST_NEXT: begin
        box_r <= box_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  cbp_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (product)
  );

  cbp_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (d2[cbp_pkg::RAD_W-1:0]),
    .done  (sqrt_done),
    .root  (root)
  );

  cbp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  assign out_strobe         = (state_r == cbp_pkg::ST_DONE);
  assign out_res.out_x      = px_r;
  assign out_res.out_z      = pz_r;
  assign out_res.push_count = count_r;
  assign out_res.popped     = pop_r;

  a_strobe_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !busy)
    else $error("result strobe not followed by idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted request did not raise busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_res.push_count <= 4'(cbp_pkg::MAX_BOXES))
    else $error("push count above box count");

  a_mul_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == cbp_pkg::ST_R2 || state_r == cbp_pkg::ST_DX
               || state_r == cbp_pkg::ST_DZ || state_r == cbp_pkg::ST_MX
               || state_r == cbp_pkg::ST_MZ))
    else $error("multiplier finished in an unexpected state");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == cbp_pkg::ST_VX || state_r == cbp_pkg::ST_VZ))
    else $error("divider finished in an unexpected state");

endmodule
`default_nettype wire
